@@ sv/rotation_to_euler_angles_top_defines.svh @@
// ----------------------------------------------------------------------------
// Rotation to Euler angles: assertion macros
// Shared assertion forms for the checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ROTATION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`define ROTATION_TO_EULER_ANGLES_TOP_DEFINES_SVH

// Property checked at every edge, reset included
`define RTEA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only outside reset
`define RTEA_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ sv/rtea_pkg.sv @@
// ----------------------------------------------------------------------------
// Rotation to Euler angles: package
// Fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rtea_pkg;

  // Angle accumulator width (Q.30 radians with headroom)
  localparam int ZW = 35;
  // Output angle width (Q3.16)
  localparam int AW = 19;
  // Width used while normalizing a Q.16 angle
  localparam int NW = 22;
  // Table length
  localparam int MAX_STEPS = 24;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [NW-1:0] PI_Q16      = 22'sd205887;
  localparam logic signed [NW-1:0] TWO_PI_Q16  = 22'sd411774;
  localparam logic signed [ZW-1:0] HALF_LSB    = 35'sd8192;

  typedef logic signed [AW-1:0] angle_t;

  // atan(2^-i) in Q.30, truncated
  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0: v = 30'h3243F6A8;
      1: v = 30'h1DAC6705;
      2: v = 30'h0FADBAFC;
      3: v = 30'h07F56EA6;
      4: v = 30'h03FEAB76;
      5: v = 30'h01FFD55B;
      6: v = 30'h00FFFAAA;
      7: v = 30'h007FFF55;
      8: v = 30'h003FFFEA;
      9: v = 30'h001FFFFD;
      10: v = 30'h000FFFFF;
      11: v = 30'h0007FFFF;
      12: v = 30'h0003FFFF;
      13: v = 30'h0001FFFF;
      14: v = 30'h0000FFFF;
      15: v = 30'h00007FFF;
      16: v = 30'h00003FFF;
      17: v = 30'h00001FFF;
      18: v = 30'h00000FFF;
      19: v = 30'h000007FF;
      20: v = 30'h000003FF;
      21: v = 30'h000001FF;
      22: v = 30'h000000FF;
      23: v = 30'h0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/rtea_atan2.sv @@
// ----------------------------------------------------------------------------
// Rotation to Euler angles: pipelined atan2
// Vectoring CORDIC, one stage per iteration, Q3.16 angle in [-pi, pi).
// ----------------------------------------------------------------------------
module rtea_atan2 #(
  parameter int W     = 34,
  parameter int STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   in_x,
  input  logic signed [W-1:0]   in_y,
  output logic                  out_valid,
  output rtea_pkg::angle_t      out_angle
);

  localparam int N  = (STEPS > rtea_pkg::MAX_STEPS) ? rtea_pkg::MAX_STEPS : STEPS;
  localparam int XW = W + 2;
  localparam int ZW = rtea_pkg::ZW;
  localparam int NW = rtea_pkg::NW;

  logic                 v_r    [0:N];
  logic                 zero_r [0:N];
  logic signed [XW-1:0] x_r    [0:N];
  logic signed [XW-1:0] y_r    [0:N];
  logic signed [ZW-1:0] z_r    [0:N];
  logic signed [XW-1:0] x_nxt  [0:N];
  logic signed [XW-1:0] y_nxt  [0:N];
  logic signed [ZW-1:0] z_nxt  [0:N];

  logic signed [XW-1:0] xe, ye;
  logic signed [ZW-1:0] zq;
  logic signed [NW-1:0] a_nxt;
  logic                 out_valid_r;
  rtea_pkg::angle_t     out_angle_r;

  // Fold the left half-plane onto the right one, then apply the micro-rotations
  always_comb begin
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    xe = {{2{in_x[W-1]}}, in_x};
    ye = {{2{in_y[W-1]}}, in_y};
    if (in_x[W-1]) begin
      x_nxt[0] = -xe;
      y_nxt[0] = -ye;
      z_nxt[0] = in_y[W-1] ? -rtea_pkg::PI_Q30 : rtea_pkg::PI_Q30;
    end else begin
      x_nxt[0] = xe;
      y_nxt[0] = ye;
      z_nxt[0] = '0;
    end
    for (int k = 0; k < N; k++) begin
      dx = y_r[k] >>> k;
      dy = x_r[k] >>> k;
      at = $signed({{(ZW-30){1'b0}}, rtea_pkg::atan_q30(k)});
      if (!y_r[k][XW-1] && (y_r[k] != '0)) begin
        x_nxt[k+1] = x_r[k] + dx;
        y_nxt[k+1] = y_r[k] - dy;
        z_nxt[k+1] = z_r[k] + at;
      end else begin
        x_nxt[k+1] = x_r[k] - dx;
        y_nxt[k+1] = y_r[k] + dy;
        z_nxt[k+1] = z_r[k] - at;
      end
    end
  end

  // Round to Q.16 and wrap into [-pi, pi)
  always_comb begin
    zq    = (z_r[N] + rtea_pkg::HALF_LSB) >>> 14;
    a_nxt = zq[NW-1:0];
    if (a_nxt >= rtea_pkg::PI_Q16) begin
      a_nxt = a_nxt - rtea_pkg::TWO_PI_Q16;
    end
    if (a_nxt < -rtea_pkg::PI_Q16) begin
      a_nxt = a_nxt + rtea_pkg::TWO_PI_Q16;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) v_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= N; k++) v_r[k] <= v_r[k-1];
      out_valid_r <= v_r[N];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    for (int k = 0; k <= N; k++) begin
      x_r[k] <= x_nxt[k];
      y_r[k] <= y_nxt[k];
      z_r[k] <= z_nxt[k];
    end
    for (int k = 1; k <= N; k++) zero_r[k] <= zero_r[k-1];
    out_angle_r <= zero_r[N] ? '0 : a_nxt[rtea_pkg::AW-1:0];
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

endmodule

@@ sv/rotation_to_euler_angles_top.sv @@
// ----------------------------------------------------------------------------
// Rotation to Euler angles: top level
// Yaw, pitch and roll from a rotation matrix, fully pipelined CORDIC.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         start / busy         in_r00 .. in_r20, Q2.16
// result    out        out_valid strobe     out_yaw/pitch/roll_angle, Q3.16
//
// One matrix per cycle; busy stays low. CORDIC_STEPS is clamped to 24. The
// stages run in order: yaw atan2, sine/cosine of yaw, multiply and sum,
// then pitch and roll atan2 side by side.
// Synchronous active-low reset clears every valid bit; data in flight is lost.
// The receiver cannot stall, so no result waits.
// ----------------------------------------------------------------------------
module rotation_to_euler_angles_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [17:0]  in_r00,
  input  logic signed [17:0]  in_r01,
  input  logic signed [17:0]  in_r02,
  input  logic signed [17:0]  in_r10,
  input  logic signed [17:0]  in_r11,
  input  logic signed [17:0]  in_r12,
  input  logic signed [17:0]  in_r20,
  output logic                out_valid,
  output logic signed [18:0]  out_yaw_angle,
  output logic signed [18:0]  out_pitch_angle,
  output logic signed [18:0]  out_roll_angle
);

  localparam int N  = (CORDIC_STEPS > rtea_pkg::MAX_STEPS) ?
                      rtea_pkg::MAX_STEPS : CORDIC_STEPS;
  localparam int ZW = rtea_pkg::ZW;
  localparam int SW = 34;          // sine/cosine datapath
  localparam int YW = 34;          // yaw operands
  localparam int PW = 38;          // pitch/roll operands
  localparam int DR = 2 * N + 4;   // matrix delay to the multipliers
  localparam int DY = 2 * N + 6;   // yaw delay to the output

  logic accept;
  logic yaw_v;
  rtea_pkg::angle_t yaw_a;

  // Accept a transaction whenever start is high
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Yaw = atan2(r10, r00)
  rtea_atan2 #(.W(YW), .STEPS(CORDIC_STEPS)) u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_x      ({in_r00, 16'b0}),
    .in_y      ({in_r10, 16'b0}),
    .out_valid (yaw_v),
    .out_angle (yaw_a)
  );

  // Delay the matrix entries to the multiplier stage
  logic [7*18-1:0] rd_r [0:DR-1];
  always_ff @(posedge clk) begin
    rd_r[0] <= {in_r00, in_r01, in_r02, in_r10, in_r11, in_r12, in_r20};
    for (int k = 1; k < DR; k++) rd_r[k] <= rd_r[k-1];
  end

  // ---------------- sine / cosine of yaw ----------------
  logic                 sv_r   [0:N];
  logic                 sf_r   [0:N];
  logic signed [SW-1:0] sx_r   [0:N];
  logic signed [SW-1:0] sy_r   [0:N];
  logic signed [ZW-1:0] sz_r   [0:N];
  logic signed [SW-1:0] sx_nxt [0:N];
  logic signed [SW-1:0] sy_nxt [0:N];
  logic signed [ZW-1:0] sz_nxt [0:N];
  logic                 sf_nxt;
  logic signed [ZW-1:0] z_in;

  // Fold angles beyond a quarter turn, then run the rotation stages
  always_comb begin
    logic signed [SW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    z_in      = {{(ZW-rtea_pkg::AW-14){yaw_a[rtea_pkg::AW-1]}}, yaw_a, 14'b0};
    sx_nxt[0] = 34'sd652032874;
    sy_nxt[0] = '0;
    sf_nxt    = 1'b0;
    sz_nxt[0] = z_in;
    if (z_in > rtea_pkg::HALF_PI_Q30) begin
      sz_nxt[0] = z_in - rtea_pkg::PI_Q30;
      sf_nxt    = 1'b1;
    end else if (z_in < -rtea_pkg::HALF_PI_Q30) begin
      sz_nxt[0] = z_in + rtea_pkg::PI_Q30;
      sf_nxt    = 1'b1;
    end
    for (int k = 0; k < N; k++) begin
      dx = sy_r[k] >>> k;
      dy = sx_r[k] >>> k;
      at = $signed({{(ZW-30){1'b0}}, rtea_pkg::atan_q30(k)});
      if (!sz_r[k][ZW-1]) begin
        sx_nxt[k+1] = sx_r[k] - dx;
        sy_nxt[k+1] = sy_r[k] + dy;
        sz_nxt[k+1] = sz_r[k] - at;
      end else begin
        sx_nxt[k+1] = sx_r[k] + dx;
        sy_nxt[k+1] = sy_r[k] - dy;
        sz_nxt[k+1] = sz_r[k] + at;
      end
    end
  end

  logic signed [SW-1:0] cr, sr;
  logic signed [17:0]   c_nxt, s_nxt, c_r, s_r;
  logic                 cs_v_r;

  // Round to Q.16 and undo the fold
  always_comb begin
    cr    = (sx_r[N] + SW'(8192)) >>> 14;
    sr    = (sy_r[N] + SW'(8192)) >>> 14;
    c_nxt = sf_r[N] ? -cr[17:0] : cr[17:0];
    s_nxt = sf_r[N] ? -sr[17:0] : sr[17:0];
  end

  // ---------------- products and sums ----------------
  logic signed [17:0] d00, d01, d02, d10, d11, d12, d20;
  assign {d00, d01, d02, d10, d11, d12, d20} = rd_r[DR-1];

  logic signed [35:0] p00c_r, p10s_r, p02s_r, p12c_r, p01s_r, p11c_r;
  logic signed [34:0] ny_r;
  logic               pv_r;
  logic signed [PW-1:0] px_r, py_r, rx_r, ry_r;
  logic               qv_r;
  logic signed [18:0] nr20;

  assign nr20 = -{d20[17], d20};

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) sv_r[k] <= 1'b0;
      cs_v_r <= 1'b0;
      pv_r   <= 1'b0;
      qv_r   <= 1'b0;
    end else begin
      sv_r[0] <= yaw_v;
      for (int k = 1; k <= N; k++) sv_r[k] <= sv_r[k-1];
      cs_v_r <= sv_r[N];
      pv_r   <= cs_v_r;
      qv_r   <= pv_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    sf_r[0] <= sf_nxt;
    for (int k = 0; k <= N; k++) begin
      sx_r[k] <= sx_nxt[k];
      sy_r[k] <= sy_nxt[k];
      sz_r[k] <= sz_nxt[k];
    end
    for (int k = 1; k <= N; k++) sf_r[k] <= sf_r[k-1];
    c_r <= c_nxt;
    s_r <= s_nxt;
    // multiply
    p00c_r <= d00 * c_r;
    p10s_r <= d10 * s_r;
    p02s_r <= d02 * s_r;
    p12c_r <= d12 * c_r;
    p01s_r <= d01 * s_r;
    p11c_r <= d11 * c_r;
    ny_r   <= {nr20, 16'b0};
    // sum
    px_r <= PW'(p00c_r) + PW'(p10s_r);
    py_r <= PW'(ny_r);
    ry_r <= PW'(p02s_r) - PW'(p12c_r);
    rx_r <= PW'(p11c_r) - PW'(p01s_r);
  end

  // ---------------- pitch and roll ----------------
  logic pitch_v, roll_v;
  rtea_pkg::angle_t pitch_a, roll_a;

  rtea_atan2 #(.W(PW), .STEPS(CORDIC_STEPS)) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (qv_r),
    .in_x      (px_r),
    .in_y      (py_r),
    .out_valid (pitch_v),
    .out_angle (pitch_a)
  );

  rtea_atan2 #(.W(PW), .STEPS(CORDIC_STEPS)) u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (qv_r),
    .in_x      (rx_r),
    .in_y      (ry_r),
    .out_valid (roll_v),
    .out_angle (roll_a)
  );

  // Hold yaw alongside the rest of the pipeline
  rtea_pkg::angle_t yd_r [0:DY-1];
  always_ff @(posedge clk) begin
    yd_r[0] <= yaw_a;
    for (int k = 1; k < DY; k++) yd_r[k] <= yd_r[k-1];
  end

  assign out_valid       = pitch_v && roll_v;
  assign out_yaw_angle   = yd_r[DY-1];
  assign out_pitch_angle = pitch_a;
  assign out_roll_angle  = roll_a;

endmodule

@@ sv/rtea_checker.sv @@
// ----------------------------------------------------------------------------
// Rotation to Euler angles: port checker
// Latency and range properties seen on the top level's ports.
// ----------------------------------------------------------------------------
`include "rotation_to_euler_angles_top_defines.svh"

module rtea_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [18:0] out_yaw_angle,
  input logic signed [18:0] out_pitch_angle,
  input logic signed [18:0] out_roll_angle
);

  localparam int N   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int LAT = 3 * N + 8;
  localparam logic signed [18:0] PI_Q16 = 19'sd205887;

  logic take;
  logic in_range;

  // Flag an accepted transaction
  assign take = start && !busy;

  // Hold every angle within [-pi, pi)
  assign in_range = (out_yaw_angle >= -PI_Q16) && (out_yaw_angle < PI_Q16) &&
                    (out_pitch_angle >= -PI_Q16) && (out_pitch_angle < PI_Q16) &&
                    (out_roll_angle >= -PI_Q16) && (out_roll_angle < PI_Q16);

  // A result appears only for an accepted transaction
  `RTEA_ASSERT_ALWAYS(a_no_phantom, out_valid |-> $past(take, LAT), "result without transaction")
  // Every accepted transaction yields its result
  `RTEA_ASSERT_RUN(a_no_loss, take |-> ##LAT out_valid, "transaction lost")
  // Angles wrap into [-pi, pi)
  `RTEA_ASSERT_RUN(a_range, out_valid |-> in_range, "angle out of range")

endmodule

bind rotation_to_euler_angles_top rtea_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_rtea_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_yaw_angle   (out_yaw_angle),
  .out_pitch_angle (out_pitch_angle),
  .out_roll_angle  (out_roll_angle)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation to Euler angles: testbench
// Drives rotation matrices into the CORDIC pipeline, predicts yaw, pitch and
// roll with a bit-exact fixed-point model, and compares every output strobe.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STEPS = 16;
  localparam int LATENCY = 3 * STEPS + 8;

  typedef struct {
    rtea_pkg::angle_t yaw;
    rtea_pkg::angle_t pitch;
    rtea_pkg::angle_t roll;
  } euler_t;

  // Arithmetic shift right (floor)
  function automatic longint shr_floor(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint q30_round_q16(input longint z);
    return shr_floor(z + 8192, 14);
  endfunction

  function automatic longint wrap_angle(input longint a);
    longint r;
    r = a;
    if (r >= 205887) r = r - 411774;
    if (r < -205887) r = r + 411774;
    return r;
  endfunction

  function automatic int clamp_steps();
    return (STEPS > rtea_pkg::MAX_STEPS) ? rtea_pkg::MAX_STEPS : STEPS;
  endfunction

  // Vectoring CORDIC, Q3.16 normalized angle
  function automatic longint vector_angle(input longint yi, input longint xi);
    longint x, y, z, dx, dy;
    int n;
    x = xi; y = yi; z = 0; n = clamp_steps();
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < n; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(rtea_pkg::atan_q30(i));
      end else begin
        x -= dx; y += dy; z -= longint'(rtea_pkg::atan_q30(i));
      end
    end
    return wrap_angle(q30_round_q16(z));
  endfunction

  // Rotation CORDIC: cosine and sine of a Q3.16 angle
  function automatic void rotate_angle(input longint ang, output longint c,
                                       output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    int n;
    z = ang * 16384; x = 652032874; y = 0; flip = 0; n = clamp_steps();
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    for (int i = 0; i < n; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(rtea_pkg::atan_q30(i));
      end else begin
        x += dx; y -= dy; z += longint'(rtea_pkg::atan_q30(i));
      end
    end
    c = q30_round_q16(x);
    s = q30_round_q16(y);
    if (flip) begin
      c = -c; s = -s;
    end
  endfunction

  class euler_scoreboard;
    euler_t pending_angles[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Compute and hold the expected angles of one accepted matrix
    function void note_matrix(input longint m00, m01, m02, m10, m11, m12, m20);
      longint yaw, c, s;
      euler_t e;
      yaw = vector_angle(m10 * 65536, m00 * 65536);
      rotate_angle(yaw, c, s);
      e.yaw = rtea_pkg::angle_t'(yaw);
      e.pitch = rtea_pkg::angle_t'(vector_angle(-m20 * 65536, m00 * c + m10 * s));
      e.roll = rtea_pkg::angle_t'(vector_angle(m02 * s - m12 * c, -m01 * s + m11 * c));
      pending_angles.push_back(e);
    endfunction

    // Compare one output transaction with the oldest expectation
    function void check_angles(input rtea_pkg::angle_t yaw, pitch, roll);
      euler_t e;
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected output yaw=%0d pitch=%0d roll=%0d", $time, yaw, pitch, roll);
        errors++;
        return;
      end
      e = pending_angles.pop_front();
      if (yaw !== e.yaw) begin
        $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw);
        errors++;
      end
      if (pitch !== e.pitch) begin
        $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch);
        errors++;
      end
      if (roll !== e.roll) begin
        $display("%0t: roll expected %0d actual %0d", $time, e.roll, roll);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [17:0] in_r00 = 0, in_r01 = 0, in_r02 = 0, in_r10 = 0;
  logic signed [17:0] in_r11 = 0, in_r12 = 0, in_r20 = 0;
  logic out_valid;
  logic signed [18:0] out_yaw_angle, out_pitch_angle, out_roll_angle;

  euler_scoreboard board = new();

  rotation_to_euler_angles_top #(.CORDIC_STEPS(STEPS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_r00(in_r00), .in_r01(in_r01), .in_r02(in_r02), .in_r10(in_r10),
    .in_r11(in_r11), .in_r12(in_r12), .in_r20(in_r20),
    .out_valid(out_valid), .out_yaw_angle(out_yaw_angle),
    .out_pitch_angle(out_pitch_angle), .out_roll_angle(out_roll_angle)
  );

  always #1 clk = ~clk;

  // Note accepted inputs and check strobed outputs at each edge
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      board.note_matrix(in_r00, in_r01, in_r02, in_r10, in_r11, in_r12, in_r20);
    if (rst_n && out_valid)
      board.check_angles(out_yaw_angle, out_pitch_angle, out_roll_angle);
  end

  // Present one matrix, hold until accepted, then idle a random gap
  task automatic send_matrix(input logic signed [17:0] m [7]);
    int gap;
    start <= 1;
    in_r00 <= m[0]; in_r01 <= m[1]; in_r02 <= m[2]; in_r10 <= m[3];
    in_r11 <= m[4]; in_r12 <= m[5]; in_r20 <= m[6];
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random entry: mostly within [-1, 1] as a real rotation would be
  function automatic logic signed [17:0] pick_entry();
    case ($urandom_range(0, 9))
      0: return 18'sh1FFFF;
      1: return -18'sh20000;
      2: return 18'sd0;
      3, 4: return 18'($urandom);
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Planar rotation by yaw: r00=c, r10=s, r01=-s, r11=c, others 0
  function automatic void yaw_matrix(output logic signed [17:0] m [7]);
    real a;
    a = ($urandom_range(0, 65535) / 65536.0 - 0.5) * 6.2831853;
    m[0] = $rtoi($cos(a) * 65536.0); m[3] = $rtoi($sin(a) * 65536.0);
    m[1] = -m[3]; m[4] = m[0]; m[2] = 0; m[5] = 0; m[6] = 0;
  endfunction

  initial begin
    logic signed [17:0] m [7];
    logic signed [17:0] corners [4];
    int idle;
    corners = '{18'sh1FFFF, -18'sh20000, 18'sd0, 18'sd65536};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: zero vectors, negative x with zero y, identity, extremes
    m = '{default: 18'sd0};
    send_matrix(m);
    m = '{-18'sd65536, 0, 0, 0, -18'sd65536, 0, 0};
    send_matrix(m);
    m = '{18'sd65536, 0, 0, 0, 18'sd65536, 0, 0};
    send_matrix(m);
    m = '{-18'sd65536, 0, 0, -18'sd1, 18'sd65536, 0, 18'sd65536};
    send_matrix(m);
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < 7; k++) m[k] = corners[(i + k * (i / 4 + 1)) % 4];
      send_matrix(m);
    end
    m = '{default: 18'sh1FFFF};
    send_matrix(m);
    m = '{default: -18'sh20000};
    send_matrix(m);
    // Random: mix of real rotations and arbitrary entries
    for (int n = 0; n < 1150; n++) begin
      if ($urandom_range(0, 2) == 0) yaw_matrix(m);
      else for (int k = 0; k < 7; k++) m[k] = pick_entry();
      send_matrix(m);
    end
    start <= 0;
    idle = 0;
    while (board.pending_angles.size() != 0 && idle < 20 * LATENCY) begin
      @(posedge clk);
      idle++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (board.errors == 0 && board.pending_angles.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung run
  initial begin
    #200000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
